FILE: rtl/pdct_pkg.sv
// Shared types and constants for the prescaled down-counter timer.
`timescale 1ns / 1ps
package pdct_pkg;

   // Item kinds on the request channel
   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_CTRL  = 2'd1,
      KIND_READ  = 2'd2,
      KIND_SPARE = 2'd3
   } kind_type;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRESCALE   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIV_SELECT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELOAD     = 2'd2;

   // Divider: select 0..4, divide by 2^(select+1)
   localparam int                DIV_SELECT_BITS = 3;
   localparam int                DIV_PHASE_BITS  = 5;
   localparam logic [DIV_SELECT_BITS-1:0] DIV_SELECT_MAX = 3'd4;

   // Per-word control from the front stage to the counter
   typedef struct packed {
      logic tick_fire;   // tick word processed and the divided clock fired
      logic ctrl_fire;   // control word processed
      logic start_req;
      logic manual_update;
      logic auto_reload;
   } cnt_ctrl_type;

endpackage

FILE: rtl/pdct_clock_path.sv
// Free-running prescaler and power-of-two divider that produce the counter tick.
`timescale 1ns / 1ps
module pdct_clock_path
   import pdct_pkg::*;
#(
   parameter int PRESCALE_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [PRESCALE_BITS-1:0]   prescale,
   input  logic [DIV_SELECT_BITS-1:0] divider_select,
   output logic                       tick
);

   logic [PRESCALE_BITS-1:0]  pre_phase_ff, pre_phase_in;
   logic [DIV_PHASE_BITS-1:0] div_phase_ff, div_phase_in;
   logic                      pre_wrap;
   logic [DIV_SELECT_BITS-1:0] sel_clamped;
   logic [DIV_PHASE_BITS:0]   div_span;
   logic [DIV_PHASE_BITS-1:0] div_mask;
   logic [DIV_PHASE_BITS-1:0] div_next;

   // Prescaler wraps at prescale (or beyond, if the register was lowered)
   assign pre_wrap = (pre_phase_ff >= prescale);

   // Divider mask, select above four behaves as four
   assign sel_clamped = (divider_select > DIV_SELECT_MAX) ? DIV_SELECT_MAX : divider_select;
   assign div_span    = (DIV_PHASE_BITS + 1)'(2) << sel_clamped;
   assign div_mask    = DIV_PHASE_BITS'(div_span - (DIV_PHASE_BITS + 1)'(1));
   assign div_next    = (div_phase_ff + DIV_PHASE_BITS'(1)) & div_mask;

   assign tick = pre_wrap && (div_next == '0);

   // Phase updates, only on a processed tick word
   always_comb begin
      pre_phase_in = pre_phase_ff;
      div_phase_in = div_phase_ff;
      if (step) begin
         if (pre_wrap) begin
            pre_phase_in = '0;
            div_phase_in = div_next;
         end else begin
            pre_phase_in = pre_phase_ff + PRESCALE_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_phase_ff <= '0;
         div_phase_ff <= '0;
      end else begin
         pre_phase_ff <= pre_phase_in;
         div_phase_ff <= div_phase_in;
      end
   end

endmodule

FILE: rtl/pdct_counter.sv
// Down counter with run and auto-reload flags and zero detection.
`timescale 1ns / 1ps
module pdct_counter
   import pdct_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cnt_ctrl_type          ctrl,
   input  logic [COUNT_BITS-1:0] reload_count,
   output logic [COUNT_BITS-1:0] count_next,
   output logic                  running_next,
   output logic                  expired
);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  run_ff, run_in;
   logic                  reload_ff, reload_in;

   // Next counter state for the word in the front stage
   always_comb begin
      count_in  = count_ff;
      run_in    = run_ff;
      reload_in = reload_ff;
      expired   = 1'b0;
      if (ctrl.tick_fire && run_ff) begin
         if (count_ff == '0) begin
            // running at zero: reload or stop
            if (reload_ff) begin
               count_in = reload_count;
            end else begin
               run_in = 1'b0;
            end
            if (count_in == '0) begin
               expired = 1'b1;
            end
         end else begin
            count_in = count_ff - COUNT_BITS'(1);
            if (count_in == '0) begin
               expired = 1'b1;
               if (!reload_ff) begin
                  run_in = 1'b0;
               end
            end
         end
      end else if (ctrl.ctrl_fire) begin
         if (ctrl.manual_update) begin
            count_in = reload_count;
         end
         run_in    = ctrl.start_req;
         reload_in = ctrl.auto_reload;
      end
   end

   assign count_next   = count_in;
   assign running_next = run_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         run_ff    <= 1'b0;
         reload_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         run_ff    <= run_in;
         reload_ff <= reload_in;
      end
   end

endmodule

FILE: rtl/prescaled_down_counter_timer_core.sv
// Top level of the prescaled down-counter timer channel.
`timescale 1ns / 1ps
// One timer channel. Each tick word stands for one source clock cycle; the
// source goes through a prescaler (divide by prescale+1) and a divider
// (divide by 2^(select+1), select clamped to four), and each divided tick
// decrements the counter while it runs (at zero it reloads or stops). Control
// words load, start, stop and set auto-reload; read words just report the
// count. Every request word gives exactly one response word. The block takes
// one word per clock cycle while it is not stalled; a word is registered in
// the input register and processed when it advances: the counter and phase
// state update and its response is registered at that same edge, so the next
// word sees the new state at once. While a response is stalled the input
// register holds one more word and then the input stalls. Configuration
// writes take effect at the next clock edge and are meant to be made while the
// block is idle.
module prescaled_down_counter_timer_core
   import pdct_pkg::*;
#(
   parameter int COUNT_BITS    = 16,
   parameter int PRESCALE_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [((COUNT_BITS > PRESCALE_BITS) ? COUNT_BITS : PRESCALE_BITS)-1:0] csr_wdata,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_kind,
   input  logic                  req_start_req,
   input  logic                  req_manual_update,
   input  logic                  req_auto_reload,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COUNT_BITS-1:0] rsp_count_value,
   output logic                  rsp_expired_pulse,
   output logic                  rsp_running
);

   // Configuration registers
   logic [PRESCALE_BITS-1:0]   prescale_ff;
   logic [DIV_SELECT_BITS-1:0] div_select_ff;
   logic [COUNT_BITS-1:0]      reload_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff     <= '0;
         div_select_ff   <= '0;
         reload_count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PRESCALE:   prescale_ff     <= csr_wdata[PRESCALE_BITS-1:0];
            CSR_DIV_SELECT: div_select_ff   <= csr_wdata[DIV_SELECT_BITS-1:0];
            CSR_RELOAD:     reload_count_ff <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Input stage
   logic     in_valid_ff, in_valid_in;
   kind_type in_kind_ff;
   logic     in_start_ff, in_manual_ff, in_auto_ff;
   logic     req_take;
   logic     advance;
   logic     rsp_valid_ff, rsp_valid_in;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff   <= kind_type'(req_kind);
         in_start_ff  <= req_start_req;
         in_manual_ff <= req_manual_update;
         in_auto_ff   <= req_auto_reload;
      end
   end

   // Processing: clock path and counter
   logic         step_tick;
   logic         div_tick;
   cnt_ctrl_type cnt_ctrl;
   logic [COUNT_BITS-1:0] count_next;
   logic         running_next;
   logic         expired;

   assign step_tick = advance && (in_kind_ff == KIND_TICK);

   pdct_clock_path #(
      .PRESCALE_BITS (PRESCALE_BITS)
   ) u_clock_path (
      .clock          (clock),
      .reset          (reset),
      .step           (step_tick),
      .prescale       (prescale_ff),
      .divider_select (div_select_ff),
      .tick           (div_tick)
   );

   always_comb begin
      cnt_ctrl.tick_fire     = step_tick && div_tick;
      cnt_ctrl.ctrl_fire     = advance && (in_kind_ff == KIND_CTRL);
      cnt_ctrl.start_req     = in_start_ff;
      cnt_ctrl.manual_update = in_manual_ff;
      cnt_ctrl.auto_reload   = in_auto_ff;
   end

   pdct_counter #(
      .COUNT_BITS (COUNT_BITS)
   ) u_counter (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (cnt_ctrl),
      .reload_count (reload_count_ff),
      .count_next   (count_next),
      .running_next (running_next),
      .expired      (expired)
   );

   // Response register
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic                  rsp_expired_ff;
   logic                  rsp_running_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_count_ff   <= count_next;
         rsp_expired_ff <= expired;
         rsp_running_ff <= running_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_count_value   = rsp_count_ff;
   assign rsp_expired_pulse = rsp_expired_ff;
   assign rsp_running       = rsp_running_ff;

endmodule
